// ===== rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the sextet-to-ascii mapping of the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int SEXT_W  = 6;
  localparam int CNT_W   = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR     = 7'd61;  // '='
  localparam logic [CHAR_W-1:0] CHAR_PLUS    = 7'd43;  // '+'
  localparam logic [CHAR_W-1:0] CHAR_SLASH   = 7'd47;  // '/'
  localparam logic [CHAR_W-1:0] UPPER_OFS    = 7'd65;  // 'A' - 0
  localparam logic [CHAR_W-1:0] LOWER_OFS    = 7'd71;  // 'a' - 26
  localparam logic [CHAR_W-1:0] DIGIT_BIAS   = 7'd4;   // 52 - '0'

  localparam logic [SEXT_W-1:0] LOWER_START  = 6'd26;
  localparam logic [SEXT_W-1:0] DIGIT_START  = 6'd52;
  localparam logic [SEXT_W-1:0] PLUS_CODE    = 6'd62;

  localparam logic [CNT_W-1:0]  POS_EMPTY    = 2'd0;
  localparam logic [CNT_W-1:0]  POS_ONE      = 2'd1;
  localparam logic [CNT_W-1:0]  POS_TWO      = 2'd2;
  localparam logic [CNT_W-1:0]  FULL_GROUP   = 2'd3;
  localparam logic [CNT_W-1:0]  LAST_SLOT    = 2'd3;

  // one three-byte group waiting to be turned into four characters
  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [CNT_W-1:0]  nvalid;   // real bytes in the group, 1..3
    logic              finish;   // group ends the message
  } b64e_group_t;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXT_W-1:0] s);
    logic [CHAR_W-1:0] sw;
    sw = CHAR_W'(s);
    if (s < LOWER_START)      return sw + UPPER_OFS;
    else if (s < DIGIT_START) return sw + LOWER_OFS;
    else if (s < PLUS_CODE)   return sw - DIGIT_BIAS;
    else if (s == PLUS_CODE)  return CHAR_PLUS;
    else                      return CHAR_SLASH;
  endfunction

endpackage

// ===== rtl/b64e_if.sv =====
// ----------------------------------------------------------------------------
// b64e channel interfaces
// valid/ready byte input channel and character output channel
// ----------------------------------------------------------------------------
interface b64e_in_if;
  import b64e_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              carries_byte;
  logic              end_of_data;

  modport source (output valid, data_byte, carries_byte, end_of_data, input ready);
  modport sink   (input valid, data_byte, carries_byte, end_of_data, output ready);
endinterface

interface b64e_out_if;
  import b64e_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;
  logic              message_done;

  modport source (output valid, out_char, last_char, message_done, input ready);
  modport sink   (input valid, out_char, last_char, message_done, output ready);
endinterface

// ===== rtl/b64e_fifo.sv =====
// ----------------------------------------------------------------------------
// b64e_fifo
// two-entry register queue of pending groups between front and back
// ----------------------------------------------------------------------------
module b64e_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64e_pkg::b64e_group_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output b64e_pkg::b64e_group_t head_data
);
  import b64e_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  b64e_group_t           mem_r [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]        count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full       = (count_r == (PTR_W+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// accepts bytes, tracks the group position and hands finished groups on
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic                  clk,
  input  logic                  rst_n,
  b64e_in_if.sink               in_stream,
  input  logic                  queue_full,
  output logic                  push,
  output b64e_pkg::b64e_group_t push_data
);
  import b64e_pkg::*;

  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] pend0_r, pend0_nxt;
  logic [BYTE_W-1:0] pend1_r, pend1_nxt;
  logic              take;
  logic              has_group;
  b64e_group_t       grp;

  assign in_stream.ready = !queue_full;
  assign take            = in_stream.valid && in_stream.ready;
  assign push            = take && has_group;
  assign push_data       = grp;

  always_comb begin
    pos_nxt   = pos_r;
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    has_group = 1'b0;
    grp       = '0;

    if (in_stream.carries_byte) begin
      if (pos_r >= POS_TWO) begin
        has_group  = 1'b1;
        grp.b0     = pend0_r;
        grp.b1     = pend1_r;
        grp.b2     = in_stream.data_byte;
        grp.nvalid = FULL_GROUP;
        grp.finish = in_stream.end_of_data;
        pos_nxt    = POS_EMPTY;
      end else if (pos_r == POS_EMPTY) begin
        pend0_nxt = in_stream.data_byte;
        pos_nxt   = POS_ONE;
      end else begin
        pend1_nxt = in_stream.data_byte;
        pos_nxt   = POS_TWO;
      end
    end

    // end of message pads whatever partial group is left
    if (in_stream.end_of_data) begin
      if (pos_nxt != POS_EMPTY) begin
        has_group  = 1'b1;
        grp.b0     = pend0_nxt;
        grp.b1     = (pos_nxt == POS_TWO) ? pend1_nxt : '0;
        grp.b2     = '0;
        grp.nvalid = pos_nxt;
        grp.finish = 1'b1;
      end
      pos_nxt   = POS_EMPTY;
      pend0_nxt = '0;
      pend1_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_EMPTY;
    end else if (take) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
    end
  end

endmodule

// ===== rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// splits queued groups into sextets and sends one character per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  b64e_pkg::b64e_group_t head_data,
  output logic                  pop,
  b64e_out_if.source            out_stream
);
  import b64e_pkg::*;

  logic [CNT_W-1:0]  slot_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, done_r;
  logic              load;
  logic [SEXT_W-1:0] sx;

  assign load = head_valid && (!out_valid_r || out_stream.ready);
  assign pop  = load && (slot_r == LAST_SLOT);

  always_comb begin
    case (slot_r)
      2'd0:    sx = head_data.b0[7:2];
      2'd1:    sx = {head_data.b0[1:0], head_data.b1[7:4]};
      2'd2:    sx = {head_data.b1[3:0], head_data.b2[7:6]};
      default: sx = head_data.b2[5:0];
    endcase
    // slots past the real bytes become padding
    char_nxt = (slot_r <= head_data.nvalid) ? sextet_char(sx) : PAD_CHAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        slot_r      <= slot_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_nxt;
      last_r <= (slot_r == LAST_SLOT);
      done_r <= (slot_r == LAST_SLOT) && head_data.finish;
    end
  end

  assign out_stream.valid        = out_valid_r;
  assign out_stream.out_char     = char_r;
  assign out_stream.last_char    = last_r;
  assign out_stream.message_done = done_r;

endmodule

// ===== rtl/base64_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// in_stream takes one transaction per byte (carries_byte = 1) or a bare end
// marker (carries_byte = 0, end_of_data = 1). out_stream gives one ascii
// character per transaction; every group of four has last_char on its
// fourth character, and message_done marks the final character of a message.
// An end marker pads a partial group to four characters with '='; an end
// marker with nothing pending emits nothing.
// A completed group is written into the group queue, and its first character is
// then loaded from the queue head into the output register.
// The back end sends one character per cycle while the receiver is ready;
// the front end takes a byte every cycle while the two-entry group queue has
// room.
// Reset (rst_n low, synchronous) empties the queue, drops any partial group
// and clears out_stream.valid.
// When the receiver stalls, the output register holds its character, the
// queue fills, and in_stream.ready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  b64e_in_if.sink     in_stream,
  b64e_out_if.source  out_stream
);
  import b64e_pkg::*;

  logic        push;
  b64e_group_t push_data;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  b64e_group_t head_data;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  b64e_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule

// ===== sim/tb_base64_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder_core
// self-checking bench for the streaming base64 encoder: a table of directed
// messages, then random messages with noise, random gaps on the input side and
// random stalls on the output side, every character checked against a model
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder_core;
  import b64e_pkg::*;

  localparam int NUM_DIRECTED = 26;
  localparam int RANDOM_ITEMS = 100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [31:0] NO_TYPED = 32'h0;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              done;
  } char_rec_t;

  typedef char_rec_t [3:0] group_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              carries;
    logic              eod;
    logic [31:0]       typed;   // four ascii characters, or NO_TYPED
  } dir_row_t;

  logic clk;
  logic rst_n;

  b64e_in_if  in_if ();
  b64e_out_if out_if ();

  base64_stream_encoder_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  string alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
                     "0123456789+/"};

  // encoder state as the bench sees it
  logic [CNT_W-1:0]  grp_pos = POS_EMPTY;
  logic [BYTE_W-1:0] held [2] = '{8'h00, 8'h00};

  char_rec_t   expected_chars [$];
  dir_row_t    directed_rows [NUM_DIRECTED];
  int          error_count = 0;
  int          cycle_count = 0;
  int          ready_hold = 0;
  int unsigned ready_roll;
  bit          quiet_phase = 1'b0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic group_t make_group(input logic [BYTE_W-1:0] b0, b1, b2,
                                        input int nreal, input logic fin);
    logic [SEXT_W-1:0] sx [4];
    group_t g;
    sx[0] = b0[7:2];
    sx[1] = {b0[1:0], b1[7:4]};
    sx[2] = {b1[3:0], b2[7:6]};
    sx[3] = b2[5:0];
    for (int k = 0; k < 4; k++) begin
      g[k].ch   = (k <= nreal) ? CHAR_W'(alphabet[sx[k]]) : PAD_CHAR;
      g[k].last = (k == 3);
      g[k].done = (k == 3) && fin;
    end
    return g;
  endfunction

  task automatic encode_item(input logic [BYTE_W-1:0] data, input logic carries,
                             input logic eod, output int n, output group_t g);
    n = 0;
    g = '0;
    if (carries) begin
      if (grp_pos == POS_TWO) begin
        g = make_group(held[0], held[1], data, 3, eod);
        n = 4;
        grp_pos = POS_EMPTY;
      end else begin
        held[grp_pos[0]] = data;
        grp_pos = grp_pos + 1'b1;
      end
    end
    if (eod) begin
      if (grp_pos != POS_EMPTY) begin
        g = make_group(held[0], (grp_pos == POS_TWO) ? held[1] : 8'h00, 8'h00,
                       int'(grp_pos), 1'b1);
        n = 4;
      end
      grp_pos = POS_EMPTY;
      held[0] = 8'h00;
      held[1] = 8'h00;
    end
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 50) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(5, 20));
  endfunction

  // one input transaction: optional gap, handshake, then predict its characters
  task automatic send_item(input logic [BYTE_W-1:0] data, input logic carries,
                           input logic eod, input logic [31:0] typed);
    int gap;
    int n;
    group_t g;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= data;
    in_if.carries_byte <= carries;
    in_if.end_of_data  <= eod;
    do @(posedge clk); while (!in_if.ready);
    encode_item(data, carries, eod, n, g);
    if (typed != NO_TYPED) begin
      n = 4;
      for (int k = 0; k < 4; k++) begin
        g[k].ch   = typed[(3-k)*8 +: CHAR_W];
        g[k].last = (k == 3);
        g[k].done = (k == 3) && eod;
      end
    end
    for (int k = 0; k < n; k++) expected_chars.push_back(g[k]);
  endtask

  // output side: long ready stretches, short stalls, now and then a long one
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_if.ready <= 1'b1;
        ready_hold   <= $urandom_range(0, 12);
      end else if (ready_roll < 90) begin
        out_if.ready <= 1'b0;
        ready_hold   <= $urandom_range(0, 2);
      end else begin
        out_if.ready <= 1'b0;
        ready_hold   <= $urandom_range(5, 25);
      end
    end
  end

  always @(posedge clk) begin
    char_rec_t exp_rec;
    char_rec_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.out_char, out_if.last_char, out_if.message_done};
      if (expected_chars.size() == 0) begin
        note_error($sformatf("unexpected char %0d last %0b done %0b",
                             got.ch, got.last, got.done));
      end else begin
        exp_rec = expected_chars.pop_front();
        if (got != exp_rec)
          note_error($sformatf("exp char %0d last %0b done %0b, got char %0d last %0b done %0b",
                               exp_rec.ch, exp_rec.last, exp_rec.done,
                               got.ch, got.last, got.done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base64_stream_encoder_core verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int items_sent;
    int msg_len;
    logic [BYTE_W-1:0] b;
    logic end_with_byte;

    items_sent = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.carries_byte = 1'b0;
    in_if.end_of_data = 1'b0;
    out_if.ready = 1'b0;

    directed_rows = '{
      '{8'h00, 1'b0, 1'b1, NO_TYPED},   // empty message
      '{8'hff, 1'b0, 1'b0, NO_TYPED},   // bare item without end does nothing
      '{8'h4d, 1'b1, 1'b0, NO_TYPED},
      '{8'h61, 1'b1, 1'b0, NO_TYPED},
      '{8'h6e, 1'b1, 1'b0, "TWFu"},
      '{8'h00, 1'b0, 1'b1, NO_TYPED},   // flush on a group boundary
      '{8'h00, 1'b1, 1'b0, NO_TYPED},
      '{8'h00, 1'b1, 1'b0, NO_TYPED},
      '{8'h00, 1'b1, 1'b0, "AAAA"},
      '{8'hff, 1'b1, 1'b0, NO_TYPED},
      '{8'hff, 1'b1, 1'b0, NO_TYPED},
      '{8'hff, 1'b1, 1'b0, "////"},
      '{8'hfb, 1'b1, 1'b0, NO_TYPED},
      '{8'hef, 1'b1, 1'b0, NO_TYPED},
      '{8'hbe, 1'b1, 1'b0, "++++"},
      '{8'h4d, 1'b1, 1'b1, "TQ=="},     // byte and end together, one byte pending
      '{8'h4d, 1'b1, 1'b0, NO_TYPED},
      '{8'h61, 1'b1, 1'b0, NO_TYPED},
      '{8'h00, 1'b0, 1'b1, "TWE="},
      '{8'hff, 1'b1, 1'b0, NO_TYPED},
      '{8'hff, 1'b1, 1'b0, NO_TYPED},
      '{8'hab, 1'b0, 1'b1, "//8="},     // byte on an end marker is ignored
      '{8'h12, 1'b1, 1'b0, NO_TYPED},
      '{8'hab, 1'b0, 1'b0, NO_TYPED},   // bare item in the middle of a group
      '{8'h34, 1'b1, 1'b0, NO_TYPED},
      '{8'h56, 1'b1, 1'b1, NO_TYPED}    // byte completes the group and ends it
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].data, directed_rows[i].carries,
                directed_rows[i].eod, directed_rows[i].typed);

    while (items_sent < RANDOM_ITEMS) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      msg_len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 20))
                                            : int'($urandom_range(0, 8));
      end_with_byte = (msg_len > 0) && $urandom_range(0, 1);
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_TYPED);
        b = 8'($urandom_range(0, 255));
        send_item(b, 1'b1, end_with_byte && (i == msg_len - 1), NO_TYPED);
        items_sent++;
      end
      // messages not ended by their last byte mostly close with a bare end marker, a few run on unterminated
      if (!end_with_byte && $urandom_range(0, 7) != 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, NO_TYPED);
        items_sent++;
      end
    end

    in_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("base64_stream_encoder_core verification clean");
    end else begin
      $display("base64_stream_encoder_core verification failed");
    end
    $finish;
  end

endmodule

// ===== base64_stream_encoder_core.f =====
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_fifo.sv
rtl/b64e_front.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_core.sv
sim/tb_base64_stream_encoder_core.sv
